@@ hdl/printf_format_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// printf_format_engine_top_defines.svh
// Assertion macros used by the formatter top level.
// ----------------------------------------------------------------------------
`ifndef PRINTF_FORMAT_ENGINE_TOP_DEFINES_SVH
`define PRINTF_FORMAT_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PFE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define PFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, character codes and helpers for the printf formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    localparam int unsigned PFE_MAX_WIDTH = 64;
    localparam int unsigned WIDTH_W       = 7;   // field width register
    localparam int unsigned DIGITS        = 20;  // decimal digits of 2^64-1
    localparam int unsigned DIG_BITS      = 4 * DIGITS;
    localparam int unsigned CNT_W         = 5;   // holds up to DIGITS

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_PCT,
        PH_FLAG,
        PH_WIDTH,
        PH_L1,
        PH_L2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PAD_PRE,
        ST_SIGN,
        ST_BODY,
        ST_PAD_POST,
        ST_PCT,
        ST_CHAR
    } emit_state_t;

    typedef enum logic [1:0] {
        DG_IDLE,
        DG_DABBLE,
        DG_NORM,
        DG_READY
    } dig_state_t;

    typedef struct packed {
        logic start;  // load a new value
        logic hex;    // base 16 instead of 10
        logic wide;   // 64-bit value, else low 32 bits
        logic pop;    // drop the leading digit
    } dig_ctrl_t;

    typedef struct packed {
        logic             done;   // digits ready, leading zeros stripped
        logic [3:0]       top;    // current leading digit
        logic [CNT_W-1:0] count;  // number of significant digits
    } dig_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return HEX_CHARS[d];
    endfunction

endpackage

`default_nettype wire

@@ hdl/pfe_digits.sv @@
// ----------------------------------------------------------------------------
// pfe_digits
// Bit-serial binary to digit converter: double dabble for decimal, direct
// nibble load for hex, then a leading-zero strip one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_digits import pfe_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dig_ctrl_t ctrl,
    input  wire logic [63:0] value,
    output dig_stat_t      stat
);

    dig_state_t          state_reg, state_next;
    logic [63:0]         bin_reg, bin_next;
    logic [DIG_BITS-1:0] bcd_reg, bcd_next;
    logic [DIG_BITS-1:0] bcd_adj;
    logic [6:0]          bits_reg, bits_next;
    logic [CNT_W-1:0]    len_reg, len_next;

    // add-3 correction on every BCD digit, all digits in parallel
    always_comb begin
        logic [3:0] nib;
        for (int i = 0; i < DIGITS; i++) begin
            nib = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        bits_next  = bits_reg;
        len_next   = len_reg;

        case (state_reg)
            DG_DABBLE: begin
                bcd_next  = {bcd_adj[DIG_BITS-2:0], bin_reg[63]};
                bin_next  = {bin_reg[62:0], 1'b0};
                bits_next = bits_reg - 7'd1;
                if (bits_reg == 7'd1) begin
                    state_next = DG_NORM;
                end
            end
            DG_NORM: begin
                if (len_reg != CNT_W'(1) && bcd_reg[DIG_BITS-1 -: 4] == 4'h0) begin
                    bcd_next = {bcd_reg[DIG_BITS-5:0], 4'h0};
                    len_next = len_reg - CNT_W'(1);
                end else begin
                    state_next = DG_READY;
                end
            end
            DG_READY: begin
                if (ctrl.pop) begin
                    bcd_next = {bcd_reg[DIG_BITS-5:0], 4'h0};
                end
            end
            default: ;
        endcase

        if (ctrl.start) begin
            len_next = CNT_W'(DIGITS);
            if (ctrl.hex) begin
                bcd_next   = {16'h0, (ctrl.wide ? value : {32'h0, value[31:0]})};
                state_next = DG_NORM;
            end else begin
                bcd_next   = '0;
                bin_next   = ctrl.wide ? value : {value[31:0], 32'h0};
                bits_next  = ctrl.wide ? 7'd64 : 7'd32;
                state_next = DG_DABBLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DG_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        bits_reg <= bits_next;
        len_reg  <= len_next;
    end

    assign stat.done  = (state_reg == DG_READY);
    assign stat.top   = bcd_reg[DIG_BITS-1 -: 4];
    assign stat.count = len_reg;

endmodule

`default_nettype wire

@@ hdl/printf_format_engine_top.sv @@
// ----------------------------------------------------------------------------
// printf_format_engine_top
// Integer printf formatter: parses a format string one byte per transaction
// and streams the formatted characters out one per transaction.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction | per transaction
//  --------+----------------------------------------+-----------+----------------------
//  s_      | s_valid s_ready s_format_char s_argument | in      | one format byte + arg
//  m_      | m_valid m_ready m_out_char m_last      | out       | one character
//
//  A literal byte is accepted, then loaded into the output register; spec bytes
//  ('%', '-', width digits, 'l') and NUL produce nothing. %% loads a '%', an
//  unknown conversion '%' then the byte. A number: double-dabble shifts over the
//  32 or 64 argument bits in pfe_digits (none for hex), then leading zero digits
//  stripped one per cycle (up to 19), then characters emitted one per cycle through
//  the single output register while it is free (m_ready). %c emits its one byte.
//  Reset (aresetn low, synchronous) returns the parser to literal text and
//  empties the output register. A stall on m_ready simply holds the sequencer;
//  s_ready is high only while no transaction is in flight.
//
`default_nettype none

module printf_format_engine_top import pfe_pkg::*; #(
    parameter int unsigned MAX_WIDTH = PFE_MAX_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // format input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_format_char,
    input  wire logic [63:0] s_argument,
    // character output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last
);

`include "printf_format_engine_top_defines.svh"

    // spec parser state
    phase_t               phase_reg, phase_next;
    logic                 left_reg, left_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [1:0]           level_reg, level_next;

    // output sequencer
    emit_state_t          state_reg, state_next;
    logic [7:0]           char_reg, char_next;     // literal / %c / unknown byte
    logic                 neg_reg, neg_next;
    logic                 kind_reg, kind_next;     // 1: single char body (%c)
    logic                 emit_left_reg, emit_left_next;
    logic [WIDTH_W-1:0]   emit_width_reg, emit_width_next;
    logic [WIDTH_W-1:0]   pad_reg, pad_next;
    logic [CNT_W-1:0]     body_cnt_reg, body_cnt_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;

    // digit unit
    dig_ctrl_t            dg_ctrl;
    dig_stat_t            dg_stat;
    logic [63:0]          dg_value;

    logic                 accept;
    logic                 out_free;
    logic                 is_digit;
    logic                 in_spec;
    logic                 wide;
    logic [31:0]          mag32;
    logic [63:0]          mag64;
    logic [9:0]           w_sum;
    logic [WIDTH_W-1:0]   w_sat;
    logic [CNT_W-1:0]     txt_len;

    pfe_digits u_digits (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dg_ctrl),
        .value   (dg_value),
        .stat    (dg_stat)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign is_digit = (s_format_char inside {[CH_0:CH_9]});
    assign in_spec  = (phase_reg inside {PH_PCT, PH_FLAG, PH_WIDTH});
    assign wide     = (level_reg != 2'd0);

    // two's complement magnitudes; the most negative value maps onto itself,
    // which is its correct unsigned magnitude
    assign mag32 = ~s_argument[31:0] + 32'd1;
    assign mag64 = ~s_argument + 64'd1;

    // width accumulate, saturating; '0'..'9' carry the digit in the low nibble
    assign w_sum = {3'b000, width_reg} * 10'd10 + {6'b000000, s_format_char[3:0]};
    assign w_sat = (w_sum > 10'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : w_sum[WIDTH_W-1:0];

    // body length: sign plus significant digits, or one byte for %c
    assign txt_len = kind_reg ? CNT_W'(1) : dg_stat.count + CNT_W'(neg_reg);

    always_comb begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        width_next      = width_reg;
        level_next      = level_reg;
        state_next      = state_reg;
        char_next       = char_reg;
        neg_next        = neg_reg;
        kind_next       = kind_reg;
        emit_left_next  = emit_left_reg;
        emit_width_next = emit_width_reg;
        pad_next        = pad_reg;
        body_cnt_next   = body_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        dg_ctrl         = '0;
        dg_value        = s_argument;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (phase_reg == PH_TEXT) begin
                        if (s_format_char == CH_PCT) begin
                            phase_next = PH_PCT;
                        end else if (s_format_char != CH_NUL) begin
                            char_next  = s_format_char;
                            state_next = ST_CHAR;
                        end
                    end else if (s_format_char == CH_NUL) begin
                        // spec dropped silently
                        phase_next = PH_TEXT;
                        left_next  = 1'b0;
                        width_next = '0;
                        level_next = 2'd0;
                    end else if (phase_reg == PH_PCT && s_format_char == CH_MINUS) begin
                        left_next  = 1'b1;
                        phase_next = PH_FLAG;
                    end else if (in_spec && is_digit) begin
                        width_next = w_sat;
                        phase_next = PH_WIDTH;
                    end else if (in_spec && s_format_char == CH_L) begin
                        level_next = 2'd1;
                        phase_next = PH_L1;
                    end else if (phase_reg == PH_L1 && s_format_char == CH_L) begin
                        level_next = 2'd2;
                        phase_next = PH_L2;
                    end else begin
                        // conversion byte: snapshot the spec, then clear it
                        phase_next      = PH_TEXT;
                        left_next       = 1'b0;
                        width_next      = '0;
                        level_next      = 2'd0;
                        emit_left_next  = left_reg;
                        emit_width_next = width_reg;
                        neg_next        = 1'b0;
                        kind_next       = 1'b0;
                        case (s_format_char)
                            CH_PCT: begin
                                char_next  = CH_PCT;
                                state_next = ST_CHAR;
                            end
                            CH_C: begin
                                char_next  = s_argument[7:0];
                                kind_next  = 1'b1;
                                state_next = ST_CONV;
                            end
                            CH_D, CH_I: begin
                                dg_ctrl.start = 1'b1;
                                dg_ctrl.wide  = wide;
                                if (wide) begin
                                    neg_next = s_argument[63];
                                    dg_value = s_argument[63] ? mag64 : s_argument;
                                end else begin
                                    neg_next = s_argument[31];
                                    dg_value = {32'h0, (s_argument[31] ? mag32
                                                                       : s_argument[31:0])};
                                end
                                state_next = ST_CONV;
                            end
                            CH_U: begin
                                dg_ctrl.start = 1'b1;
                                dg_ctrl.wide  = wide;
                                state_next    = ST_CONV;
                            end
                            CH_X: begin
                                dg_ctrl.start = 1'b1;
                                dg_ctrl.hex   = 1'b1;
                                dg_ctrl.wide  = wide;
                                state_next    = ST_CONV;
                            end
                            CH_P: begin
                                dg_ctrl.start = 1'b1;
                                dg_ctrl.hex   = 1'b1;
                                dg_ctrl.wide  = 1'b1;
                                state_next    = ST_CONV;
                            end
                            default: begin
                                // unknown conversion: '%' then the byte itself
                                char_next  = s_format_char;
                                state_next = ST_PCT;
                            end
                        endcase
                    end
                end
            end

            ST_CONV: begin
                if (kind_reg || dg_stat.done) begin
                    pad_next = (emit_width_reg > WIDTH_W'(txt_len))
                             ? emit_width_reg - WIDTH_W'(txt_len) : '0;
                    body_cnt_next = kind_reg ? CNT_W'(1) : dg_stat.count;
                    state_next    = ST_PAD_PRE;
                end
            end

            ST_PAD_PRE: begin
                if (!emit_left_reg && pad_reg != '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_char_next  = CH_SPACE;
                        m_last_next  = 1'b0;
                        pad_next     = pad_reg - WIDTH_W'(1);
                    end
                end else begin
                    state_next = ST_SIGN;
                end
            end

            ST_SIGN: begin
                if (!neg_reg) begin
                    state_next = ST_BODY;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_BODY;
                end
            end

            ST_BODY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_char_next   = kind_reg ? char_reg : digit_char(dg_stat.top);
                    m_last_next   = (body_cnt_reg == CNT_W'(1)) && (pad_reg == '0);
                    dg_ctrl.pop   = !kind_reg;
                    body_cnt_next = body_cnt_reg - CNT_W'(1);
                    if (body_cnt_reg == CNT_W'(1)) begin
                        state_next = (pad_reg != '0) ? ST_PAD_POST : ST_IDLE;
                    end
                end
            end

            ST_PAD_POST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_SPACE;
                    m_last_next  = (pad_reg == WIDTH_W'(1));
                    pad_next     = pad_reg - WIDTH_W'(1);
                    if (pad_reg == WIDTH_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_PCT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CH_PCT;
                    m_last_next  = 1'b0;
                    state_next   = ST_CHAR;
                end
            end

            ST_CHAR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = char_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TEXT;
            left_reg    <= 1'b0;
            width_reg   <= '0;
            level_reg   <= 2'd0;
            state_reg   <= ST_IDLE;
            pad_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            width_reg   <= width_next;
            level_reg   <= level_next;
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            m_valid_reg <= m_valid_next;
        end
        char_reg       <= char_next;
        neg_reg        <= neg_next;
        kind_reg       <= kind_next;
        emit_left_reg  <= emit_left_next;
        emit_width_reg <= emit_width_next;
        body_cnt_reg   <= body_cnt_next;
        m_char_reg     <= m_char_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_last     = m_last_reg;

    // ---------------------------------------------------------------- checks
    `PFE_ASSERT_NOW(a_width_sat, aclk, aresetn, 1'b1, width_reg <= WIDTH_W'(MAX_WIDTH), "field width above limit")
    `PFE_ASSERT_NOW(a_pad_spent, aclk, aresetn, state_reg == ST_IDLE, pad_reg == '0, "padding left over at idle")
    `PFE_ASSERT_NOW(a_digits_ready, aclk, aresetn, state_reg == ST_BODY && !kind_reg, dg_stat.done, "digit emitted before conversion done")
    `PFE_ASSERT_NEXT(a_literal_echo, aclk, aresetn, accept && phase_reg == PH_TEXT && s_format_char != CH_NUL && s_format_char != CH_PCT, state_reg == ST_CHAR, "literal byte not echoed")

endmodule

`default_nettype wire
